[hdl/adcm_pkg.sv]
// Shared constants and types for the ADC stuck and frozen monitor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package adcm_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = 8;
  localparam int COUNT_W   = 8;
  localparam int LIMIT_W   = 6;
  localparam int SECONDS_W = 32;
  localparam int FLAGS_W   = 3;

  localparam logic [SAMPLE_W-1:0] ZERO_MV_MAX   = 12'd5;
  localparam logic [SAMPLE_W-1:0] FULL_MV_MIN   = 12'd3290;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP    = 12'd4095;
  localparam logic [COUNT_W-1:0]  COUNT_CEIL    = 8'd255;
  localparam logic [LIMIT_W-1:0]  LIMIT_DEFAULT = 6'd5;
  localparam logic [LIMIT_W-1:0]  LIMIT_MIN     = 6'd3;

  localparam int FLAG_ZERO   = 0;
  localparam int FLAG_FULL   = 1;
  localparam int FLAG_FROZEN = 2;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [SECONDS_W-1:0] seconds_t;

  typedef struct packed {
    logic flag;
    logic report;
  } trk_res_t;

  typedef struct packed {
    sample_t  max_seen;
    sample_t  min_seen;
    level_t   peak_level;
    seconds_t seconds;
  } stats_t;

endpackage

`default_nettype wire

[hdl/adcm_fault_track.sv]
// One saturating fault counter with its error flag and one-shot report.
// Depends on adcm_pkg for widths, limits and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module adcm_fault_track
  import adcm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire logic     cond,
  input  wire limit_t   limit,
  output trk_res_t      res
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               reported_r, reported_nxt;
  logic               flag_r, flag_nxt;
  logic               hit;

  always_comb begin
    if (cond) begin
      count_nxt = (count_r == COUNT_CEIL) ? COUNT_CEIL : count_r + 1'b1;
    end else begin
      count_nxt = '0;
    end
    hit          = cond && (count_nxt >= {{(COUNT_W-LIMIT_W){1'b0}}, limit});
    flag_nxt     = cond && (flag_r || hit);
    reported_nxt = cond && (reported_r || hit);
    res.flag     = flag_nxt;
    res.report   = hit && !reported_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      reported_r <= 1'b0;
      flag_r     <= 1'b0;
    end else if (step) begin
      count_r    <= count_nxt;
      reported_r <= reported_nxt;
      flag_r     <= flag_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/adcm_stats.sv]
// Running sample minimum and maximum, peak level and elapsed seconds.
// Depends on adcm_pkg for widths and the statistics struct.
`timescale 1ns / 1ps
`default_nettype none

module adcm_stats
  import adcm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire sample_t sample,
  input  wire level_t  level,
  output stats_t       stats
);

  sample_t  max_r, min_r;
  level_t   peak_r;
  seconds_t seconds_r;
  logic     phase_r;

  always_comb begin
    stats.max_seen   = (sample > max_r) ? sample : max_r;
    stats.min_seen   = (sample < min_r) ? sample : min_r;
    stats.peak_level = (level > peak_r) ? level : peak_r;
    stats.seconds    = phase_r ? seconds_r + 1'b1 : seconds_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      min_r     <= SAMPLE_TOP;
      peak_r    <= '0;
      seconds_r <= '0;
      phase_r   <= 1'b0;
    end else if (step) begin
      max_r     <= stats.max_seen;
      min_r     <= stats.min_seen;
      peak_r    <= stats.peak_level;
      seconds_r <= stats.seconds;
      phase_r   <= !phase_r;
    end
  end

endmodule

`default_nettype wire

[hdl/adc_stuck_and_frozen_monitor_core.sv]
// Top level of the ADC stuck and frozen monitor: input register, fault
// trackers, statistics and result register. Depends on adcm_pkg,
// adcm_fault_track and adcm_stats.
//
// Each input word carries one sensor sample in millivolts and an alarm level.
// Each accepted word yields exactly one result word with the error flags,
// three one-shot report bits, the running sample minimum and maximum, the
// peak level and the elapsed seconds (one per two samples).
// The fault limit is written through the cfg channel, which is always ready;
// values below three act as five. Write it only while the block is idle.
// A word is registered on acceptance, and its result is registered in the
// result register when it is free, that is empty or being read out.
// Throughput is one word per cycle while out_ready is high, set by the single
// pass of compare and counter logic between the input and result registers.
// When the receiver holds out_ready low the result register holds its word,
// the input register still takes one more word, and in_ready then falls
// until the result is taken.
// Reset clears all counters, flags and statistics, empties both registers
// and sets the fault limit to five.
`timescale 1ns / 1ps
`default_nettype none

module adc_stuck_and_frozen_monitor_core
  import adcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample_mv,
  input  wire logic [LEVEL_W-1:0]   in_level,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FLAGS_W-1:0]        out_error_flags,
  output logic                      out_zero_report,
  output logic                      out_full_report,
  output logic                      out_frozen_report,
  output logic [SAMPLE_W-1:0]       out_sample_max,
  output logic [SAMPLE_W-1:0]       out_sample_min,
  output logic [LEVEL_W-1:0]        out_peak_level,
  output logic [SECONDS_W-1:0]      out_run_seconds,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIMIT_W-1:0]   cfg_fault_limit
);

  logic     in_valid_r;
  sample_t  in_sample_r;
  level_t   in_level_r;
  limit_t   limit_r;
  sample_t  prev_r;
  logic     prev_valid_r;

  logic     out_valid_r;
  logic [FLAGS_W-1:0] flags_r;
  logic     zero_rep_r, full_rep_r, frozen_rep_r;
  stats_t   stats_r;

  logic     out_free;
  logic     adv;
  limit_t   limit_eff;
  logic     zero_cond, full_cond, same;
  trk_res_t zero_res, full_res, frozen_res;
  stats_t   stats_nxt;

  assign out_free  = !out_valid_r || out_ready;
  assign adv       = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign cfg_ready = 1'b1;

  assign limit_eff = (limit_r < LIMIT_MIN) ? LIMIT_DEFAULT : limit_r;
  assign zero_cond = (in_sample_r <= ZERO_MV_MAX);
  assign full_cond = (in_sample_r >= FULL_MV_MIN);
  assign same      = prev_valid_r && (in_sample_r == prev_r);

  adcm_fault_track u_zero (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .cond  (zero_cond),
    .limit (limit_eff),
    .res   (zero_res)
  );

  adcm_fault_track u_full (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .cond  (full_cond),
    .limit (limit_eff),
    .res   (full_res)
  );

  adcm_fault_track u_frozen (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .cond  (same),
    .limit (limit_eff),
    .res   (frozen_res)
  );

  adcm_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .sample (in_sample_r),
    .level  (in_level_r),
    .stats  (stats_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      limit_r      <= LIMIT_DEFAULT;
      prev_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r  <= 1'b1;
        prev_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        limit_r <= cfg_fault_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_sample_mv;
      in_level_r  <= in_level;
    end
    if (adv) begin
      prev_r                <= in_sample_r;
      flags_r[FLAG_ZERO]    <= zero_res.flag;
      flags_r[FLAG_FULL]    <= full_res.flag;
      flags_r[FLAG_FROZEN]  <= frozen_res.flag;
      zero_rep_r            <= zero_res.report;
      full_rep_r            <= full_res.report;
      frozen_rep_r          <= frozen_res.report;
      stats_r               <= stats_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_error_flags   = flags_r;
  assign out_zero_report   = zero_rep_r;
  assign out_full_report   = full_rep_r;
  assign out_frozen_report = frozen_rep_r;
  assign out_sample_max    = stats_r.max_seen;
  assign out_sample_min    = stats_r.min_seen;
  assign out_peak_level    = stats_r.peak_level;
  assign out_run_seconds   = stats_r.seconds;

`ifndef ASSERT_OFF
  a_adv_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after an input word moved on");

  a_held_input_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r && $stable(in_sample_r))
    else $error("stalled input word lost");

  a_report_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!zero_rep_r || flags_r[FLAG_ZERO]) &&
                    (!full_rep_r || flags_r[FLAG_FULL]) &&
                    (!frozen_rep_r || flags_r[FLAG_FROZEN]))
    else $error("report pulse without its error flag");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> stats_r.min_seen <= stats_r.max_seen)
    else $error("sample minimum above sample maximum");
`endif

endmodule

`default_nettype wire

[tb/tb_adc_stuck_and_frozen_monitor_core.sv]
// Self-checking testbench for adc_stuck_and_frozen_monitor_core: directed and random
// sample words with random stalls on both sides, checked against a built-in predictor.
// Depends on adcm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_adc_stuck_and_frozen_monitor_core;
  import adcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTED   = 10;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic               zero_report;
    logic               full_report;
    logic               frozen_report;
    sample_t            sample_max;
    sample_t            sample_min;
    level_t             peak_level;
    seconds_t           run_seconds;
  } health_word_t;

  typedef enum int {
    RUN_HELD_ANY,
    RUN_HELD_LOW,
    RUN_HELD_HIGH,
    RUN_LOW_BAND,
    RUN_HIGH_BAND,
    RUN_EDGES,
    RUN_NOISE
  } run_kind_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sample_t            in_sample_mv = '0;
  level_t             in_level = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FLAGS_W-1:0] out_error_flags;
  logic               out_zero_report;
  logic               out_full_report;
  logic               out_frozen_report;
  sample_t            out_sample_max;
  sample_t            out_sample_min;
  level_t             out_peak_level;
  seconds_t           out_run_seconds;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  limit_t             cfg_fault_limit = '0;

  // Predictor state.
  limit_t             limit_reg;
  logic [COUNT_W-1:0] run_len [FLAGS_W];
  logic [15:0]        last_mv;
  logic [FLAGS_W-1:0] reported;
  logic [FLAGS_W-1:0] fault_flags;
  sample_t            max_mv;
  sample_t            min_mv;
  level_t             peak_lvl;
  logic               half_phase;
  seconds_t           seconds;

  health_word_t       expected_health[$];
  int                 mismatches = 0;
  int                 results_checked = 0;
  int                 idle_cycles = 0;
  int                 rx_wait = 0;
  int                 tx_gap_max = 14;
  int                 rx_gap_max = 14;

  adc_stuck_and_frozen_monitor_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_mv      (in_sample_mv),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_error_flags   (out_error_flags),
    .out_zero_report   (out_zero_report),
    .out_full_report   (out_full_report),
    .out_frozen_report (out_frozen_report),
    .out_sample_max    (out_sample_max),
    .out_sample_min    (out_sample_min),
    .out_peak_level    (out_peak_level),
    .out_run_seconds   (out_run_seconds),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_fault_limit   (cfg_fault_limit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic reset_health_model();
    limit_reg   = LIMIT_DEFAULT;
    for (int i = 0; i < FLAGS_W; i++) run_len[i] = '0;
    last_mv     = 16'hFFFF;
    reported    = '0;
    fault_flags = '0;
    max_mv      = '0;
    min_mv      = SAMPLE_TOP;
    peak_lvl    = '0;
    half_phase  = 1'b0;
    seconds     = '0;
  endtask

  function automatic health_word_t predict_health(sample_t mv, level_t lv);
    health_word_t       w;
    logic [FLAGS_W-1:0] cond;
    logic [FLAGS_W-1:0] fired;
    limit_t             eff_limit;
    w = '0;
    fired = '0;
    if (lv > peak_lvl) peak_lvl = lv;
    if (mv > max_mv) max_mv = mv;
    if (mv < min_mv) min_mv = mv;
    if (half_phase) begin
      seconds = seconds + 1'b1;
      half_phase = 1'b0;
    end else begin
      half_phase = 1'b1;
    end
    eff_limit = (limit_reg < LIMIT_MIN) ? LIMIT_DEFAULT : limit_reg;
    cond[FLAG_ZERO]   = (mv <= ZERO_MV_MAX);
    cond[FLAG_FULL]   = (mv >= FULL_MV_MIN);
    cond[FLAG_FROZEN] = ({4'd0, mv} == last_mv);
    for (int i = 0; i < FLAGS_W; i++) begin
      if (cond[i]) begin
        if (run_len[i] != COUNT_CEIL) run_len[i] = run_len[i] + 1'b1;
      end else begin
        run_len[i] = '0;
        reported[i] = 1'b0;
        fault_flags[i] = 1'b0;
      end
    end
    if (!cond[FLAG_FROZEN]) last_mv = {4'd0, mv};
    for (int i = 0; i < FLAGS_W; i++) begin
      if (run_len[i] >= {2'b00, eff_limit}) begin
        fault_flags[i] = 1'b1;
        if (!reported[i]) begin
          reported[i] = 1'b1;
          fired[i] = 1'b1;
        end
      end
    end
    w.flags         = fault_flags;
    w.zero_report   = fired[FLAG_ZERO];
    w.full_report   = fired[FLAG_FULL];
    w.frozen_report = fired[FLAG_FROZEN];
    w.sample_max    = max_mv;
    w.sample_min    = min_mv;
    w.peak_level    = peak_lvl;
    w.run_seconds   = seconds;
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_fault_limit;
      if (in_valid && in_ready) expected_health.push_back(predict_health(in_sample_mv, in_level));
    end
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("Mismatch in result word %0d, %s: expected %0d, got %0d",
                 results_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    health_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_health.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("Unexpected result word %0d with no prediction waiting", results_checked);
      end else begin
        want = expected_health.pop_front();
        compare_field("error_flags", 32'(want.flags), 32'(out_error_flags));
        compare_field("zero_report", 32'(want.zero_report), 32'(out_zero_report));
        compare_field("full_report", 32'(want.full_report), 32'(out_full_report));
        compare_field("frozen_report", 32'(want.frozen_report), 32'(out_frozen_report));
        compare_field("sample_max", 32'(want.sample_max), 32'(out_sample_max));
        compare_field("sample_min", 32'(want.sample_min), 32'(out_sample_min));
        compare_field("peak_level", 32'(want.peak_level), 32'(out_peak_level));
        compare_field("run_seconds", want.run_seconds, out_run_seconds);
      end
      results_checked++;
    end
  end

  // After every word it takes, the receiver stalls for a freshly drawn random wait up to rx_gap_max.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_wait = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_wait = $urandom_range(0, rx_gap_max);
      else if (rx_wait > 0) rx_wait = rx_wait - 1;
      out_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
        $display("** adc_stuck_and_frozen_monitor_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_sample(input sample_t mv, input level_t lv);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_mv <= mv;
    in_level     <= lv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_health.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fault_limit(input limit_t value);
    cfg_valid       <= 1'b1;
    cfg_fault_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t draw_sample(run_kind_t kind);
    case (kind)
      RUN_HELD_LOW, RUN_LOW_BAND:   return sample_t'($urandom_range(0, ZERO_MV_MAX));
      RUN_HELD_HIGH, RUN_HIGH_BAND: return sample_t'($urandom_range(FULL_MV_MIN, SAMPLE_TOP));
      RUN_EDGES: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return ZERO_MV_MAX;
          2:       return sample_t'(ZERO_MV_MAX + 1'b1);
          3:       return sample_t'(FULL_MV_MIN - 1'b1);
          4:       return FULL_MV_MIN;
          default: return SAMPLE_TOP;
        endcase
      end
      default: return sample_t'($urandom_range(0, SAMPLE_TOP));
    endcase
  endfunction

  task automatic send_random_samples(input int count, input int run_max);
    int        sent;
    int        len;
    run_kind_t kind;
    sample_t   mv;
    sent = 0;
    while (sent < count) begin
      kind = run_kind_t'($urandom_range(RUN_HELD_ANY, RUN_NOISE));
      len  = (kind == RUN_NOISE) ? $urandom_range(1, 6) : $urandom_range(1, run_max);
      mv   = draw_sample(kind);
      for (int k = 0; k < len && sent < count; k++) begin
        if (kind > RUN_HELD_HIGH) mv = draw_sample(kind);
        send_sample(mv, level_t'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic test_first_sample();
    send_sample(SAMPLE_TOP, 8'd255);
    send_sample('0, 8'd0);
  endtask

  // Varying values of 5 mV or less, so only the zero counter runs; reset limit applies.
  task automatic test_zero_stuck();
    send_sample(12'd5, 8'd1);
    send_sample(12'd3, 8'd2);
    send_sample(12'd0, 8'd3);
    send_sample(12'd1, 8'd4);
    send_sample(12'd2, 8'd5);
    send_sample(12'd4, 8'd6);
    send_sample(sample_t'(ZERO_MV_MAX + 1'b1), 8'd7);
  endtask

  task automatic test_full_and_frozen();
    wait_drained();
    write_fault_limit(LIMIT_MIN);
    repeat (4) send_sample(FULL_MV_MIN, 8'd10);
    send_sample(SAMPLE_TOP, 8'd11);
    send_sample(sample_t'(FULL_MV_MIN - 1'b1), 8'd12);
  endtask

  // A limit below three must behave as the default of five.
  task automatic test_small_limit();
    wait_drained();
    write_fault_limit(limit_t'(2));
    send_sample(12'd4000, 8'd255);
    repeat (5) send_sample(12'd4000, 8'd0);
  endtask

  task automatic test_counter_ceiling();
    wait_drained();
    write_fault_limit(limit_t'(63));
    repeat (300) send_sample('0, level_t'($urandom_range(0, 255)));
    send_sample(12'd100, 8'd0);
  endtask

  task automatic test_random_phases();
    limit_t limits [7];
    limit_t eff;
    limits = '{limit_t'(3), limit_t'(60), limit_t'(0), limit_t'(63), limit_t'(1),
               limit_t'($urandom_range(3, 60)), LIMIT_DEFAULT};
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_fault_limit(limits[p]);
      tx_gap_max = (p % 3 == 1) ? 0 : 14;
      rx_gap_max = (p % 3 == 2) ? 0 : 14;
      eff = (limits[p] < LIMIT_MIN) ? LIMIT_DEFAULT : limits[p];
      send_random_samples(210, int'(eff) + 4);
    end
    tx_gap_max = 14;
    rx_gap_max = 14;
  endtask

  initial begin
    reset_health_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample();
    test_zero_stuck();
    test_full_and_frozen();
    test_small_limit();
    test_counter_ceiling();
    test_random_phases();
    wait_drained();
    mismatches += expected_health.size();
    if (mismatches == 0) begin
      $display("** adc_stuck_and_frozen_monitor_core: PASSED **");
    end else begin
      $display("** adc_stuck_and_frozen_monitor_core: FAILED **");
    end
    $finish;
  end

endmodule
